// ===== rtl/core/plid_pkg.sv =====
// ----------------------------------------------------------------------------
// plid_pkg
// Shared types and constants for the positional list insert/delete block.
// ----------------------------------------------------------------------------
package plid_pkg;

  // list geometry
  localparam int LIST_DEPTH = 16;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W      = $clog2(LIST_DEPTH);

  // command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // operation codes of the input word
  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_INS_TAIL = 3'd2,
    OP_INS_POS  = 3'd3,
    OP_DEL_HEAD = 3'd4,
    OP_DEL_TAIL = 3'd5,
    OP_DEL_POS  = 3'd6
  } op_code_t;

  // status carried on every result of an item
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // decoded command kind and target place
  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_INS,
    CMD_DEL
  } kind_t;

  typedef enum logic [1:0] {
    AT_HEAD,
    AT_TAIL,
    AT_POS
  } where_t;

  // input word
  typedef struct packed {
    op_code_t           operation;
    logic signed [31:0] value;
    logic [4:0]         position;
  } op_word_t;

  // result word
  typedef struct packed {
    logic signed [31:0] element;
    logic [3:0]         element_index;
    status_t            status;
    logic               list_empty;
    logic               last;
  } result_word_t;

  // classified command held in the queue
  typedef struct packed {
    kind_t              kind;
    where_t             where;
    logic signed [31:0] value;
    logic [4:0]         position;
  } cmd_t;

  // back-end back-end state
  typedef enum logic {
    S_IDLE,
    S_DUMP
  } back_state_t;

endpackage

// ===== rtl/core/plid_front.sv =====
// ----------------------------------------------------------------------------
// plid_front
// Accepts operation words and classifies them into queue commands.
// ----------------------------------------------------------------------------
module plid_front
  import plid_pkg::*;
(
  input  logic     start,
  input  op_word_t cmd,
  input  logic     q_full,
  output logic     busy,
  output logic     push,
  output cmd_t     push_cmd
);

  // hold off new words while the queue has no room
  assign busy = q_full;
  assign push = start && !q_full;

  // decode operation code into kind and target place
  always_comb begin
    push_cmd.value    = cmd.value;
    push_cmd.position = cmd.position;
    push_cmd.kind     = CMD_NOP;
    push_cmd.where    = AT_HEAD;
    unique case (cmd.operation)
      OP_INS_HEAD: begin
        push_cmd.kind  = CMD_INS;
        push_cmd.where = AT_HEAD;
      end
      OP_INS_TAIL: begin
        push_cmd.kind  = CMD_INS;
        push_cmd.where = AT_TAIL;
      end
      OP_INS_POS: begin
        push_cmd.kind  = CMD_INS;
        push_cmd.where = AT_POS;
      end
      OP_DEL_HEAD: begin
        push_cmd.kind  = CMD_DEL;
        push_cmd.where = AT_HEAD;
      end
      OP_DEL_TAIL: begin
        push_cmd.kind  = CMD_DEL;
        push_cmd.where = AT_TAIL;
      end
      OP_DEL_POS: begin
        push_cmd.kind  = CMD_DEL;
        push_cmd.where = AT_POS;
      end
      default: begin
        push_cmd.kind  = CMD_NOP;
        push_cmd.where = AT_HEAD;
      end
    endcase
  end

endmodule

// ===== rtl/core/plid_fifo.sv =====
// ----------------------------------------------------------------------------
// plid_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module plid_fifo
  import plid_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic valid,
  output cmd_t head
);

  cmd_t            slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   fill;

  assign full  = (fill == (Q_AW+1)'(Q_DEPTH));
  assign valid = (fill != '0);
  assign head  = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

endmodule

// ===== rtl/core/plid_back.sv =====
// ----------------------------------------------------------------------------
// plid_back
// Applies queued commands to the list cells and dumps the list.
// ----------------------------------------------------------------------------
module plid_back
  import plid_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  cmd_t         q_cmd,
  output logic         q_pop,
  output logic         result_valid,
  output result_word_t result
);

  logic signed [31:0] cells [LIST_DEPTH];
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [IDX_W-1:0]   k;
  status_t            status;
  status_t            status_next;
  back_state_t        state;
  back_state_t        state_next;

  logic             do_ins;
  logic             do_del;
  logic [CNT_W-1:0] op_pos;
  logic             emit;
  logic             dump_last;

  // next state, command checks and dump control
  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    do_ins      = 1'b0;
    do_del      = 1'b0;
    op_pos      = '0;
    count_next  = count;
    status_next = status;
    emit        = 1'b0;
    dump_last   = (count == '0) || ((CNT_W'(k) + 1'b1) == count);
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          status_next = ST_DONE;
          state_next  = S_DUMP;
          case (q_cmd.kind)
            CMD_INS: begin
              case (q_cmd.where)
                AT_TAIL: op_pos = count;
                AT_POS:  op_pos = CNT_W'(q_cmd.position);
                default: op_pos = '0;
              endcase
              if (q_cmd.where == AT_POS && 32'(q_cmd.position) > 32'(count)) begin
                status_next = ST_BADPOS;
              end else if (count == CNT_W'(LIST_DEPTH)) begin
                status_next = ST_FULL;
              end else begin
                do_ins     = 1'b1;
                count_next = count + 1'b1;
              end
            end
            CMD_DEL: begin
              case (q_cmd.where)
                AT_TAIL: op_pos = count - 1'b1;
                AT_POS:  op_pos = CNT_W'(q_cmd.position);
                default: op_pos = '0;
              endcase
              if (q_cmd.where == AT_POS) begin
                if (32'(q_cmd.position) >= 32'(count)) begin
                  status_next = ST_BADPOS;
                end else begin
                  do_del     = 1'b1;
                  count_next = count - 1'b1;
                end
              end else if (count != '0) begin
                do_del     = 1'b1;
                count_next = count - 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        emit = 1'b1;
        if (dump_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      status       <= ST_DONE;
      k            <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      status       <= status_next;
      result_valid <= emit;
      if (state == S_IDLE)  k <= '0;
      else if (!dump_last)  k <= k + 1'b1;
    end
  end

  // list cells shift on insert or delete; insert writes the place
  always_ff @(posedge clk) begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (do_ins) begin
        if (CNT_W'(i) == op_pos)     cells[i] <= q_cmd.value;
        else if (CNT_W'(i) > op_pos) cells[i] <= cells[(i > 0) ? i - 1 : 0];
      end else if (do_del) begin
        if (CNT_W'(i) >= op_pos && i < LIST_DEPTH - 1)
          cells[i] <= cells[(i < LIST_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // registered result word
  always_ff @(posedge clk) begin
    if (emit) begin
      result.element       <= (count == '0) ? 32'sd0 : cells[k];
      result.element_index <= 4'(k);
      result.status        <= status;
      result.list_empty    <= (count == '0);
      result.last          <= dump_last;
    end
  end

endmodule

// ===== rtl/core/positional_list_insert_delete_top.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_delete_top
// Ordered list of signed 32-bit values with positional insert and delete.
// ----------------------------------------------------------------------------
// Usage:
//   Drive cmd and raise start; the word is taken at a clock edge where start
//   is high and busy is low. busy is high only while the two-entry command
//   queue is full, so two words can be taken back to back.
//   Each word updates the list in the back part, then the whole
//   list is dumped on result, one element per cycle from the head, each
//   marked by result_valid for exactly one cycle, the final one with last.
//   An empty list gives one word with list_empty set.
//   A word taken while the back part is idle passes the command queue and
//   is applied to the list at the next edge; its first result then comes
//   out of the result register. The back part takes the next queued word
//   only once the dump of the last one has ended and it is idle again.
//   The receiver cannot hold results off; it must take every word shown.
//   Reset (rst, synchronous) empties the list and the queue.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_top
  import plid_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  op_word_t     cmd,
  output logic         busy,
  output logic         result_valid,
  output result_word_t result
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t q_head;

  plid_front u_front (
    .start    (start),
    .cmd      (cmd),
    .q_full   (q_full),
    .busy     (busy),
    .push     (push),
    .push_cmd (push_cmd)
  );

  plid_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head)
  );

  plid_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ===== rtl/core/plid_checker.sv =====
// ----------------------------------------------------------------------------
// plid_checker
// Port-level checks on the dump sequence of the list block.
// ----------------------------------------------------------------------------
module plid_checker
  import plid_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         result_valid,
  input result_word_t result
);

  // an empty dump is a single word at index zero
  a_empty_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.list_empty |-> result.last && result.element_index == 4'd0)
    else $error("empty dump not a single word");

  // dump words come in consecutive cycles with rising index
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |=>
      result_valid && result.element_index == 4'($past(result.element_index) + 4'd1))
    else $error("dump index gap");

  // one status for the whole dump of a word
  a_status_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |=> result.status == $past(result.status))
    else $error("status changed inside a dump");

  // a gap cycle follows the end of every dump
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |=> !result_valid)
    else $error("no gap after last word");

endmodule

bind positional_list_insert_delete_top plid_checker u_plid_checker (.*);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional list insert/delete block. Command
// words go in through the start/busy handshake and the dump words coming
// back are checked field by field against a shadow copy of the list. A
// short directed script covers the empty list, bad positions, the full
// list and the value extremes. Random words follow, sweeping the list
// between empty and full with random sender gaps.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import plid_pkg::*;

  // unused operation code, must leave the list alone
  localparam op_code_t OP_UNUSED = op_code_t'(3'd7);
  localparam int STALL_LIMIT = 1000;
  localparam int N_RANDOM    = 340;

  logic         clk;
  logic         rst;
  logic         start;
  op_word_t     cmd;
  logic         busy;
  logic         result_valid;
  result_word_t result;

  // one line of the directed script; reps > 1 repeats with random values
  typedef struct {
    op_code_t    op;
    logic [31:0] value;
    logic [4:0]  position;
    int          reps;
    bit          typed;
    status_t     st;
    int          len;
  } script_row_t;

  script_row_t        script[$];
  result_word_t       pending_dump[$];
  logic signed [31:0] shadow_list [LIST_DEPTH];
  logic [CNT_W-1:0]   shadow_count;
  bit                 growing;
  int                 n_fail;
  int                 n_sent;
  int                 n_checked;
  int                 n_full_hits;
  int                 n_empty_hits;

  positional_list_insert_delete_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .cmd         (cmd),
    .busy        (busy),
    .result_valid(result_valid),
    .result      (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // shadow list: insert at a place, returns the status of the insert
  function automatic status_t list_put(int at, logic signed [31:0] v);
    int i;
    if (shadow_count >= LIST_DEPTH) return ST_FULL;
    for (i = int'(shadow_count); i > at; i--) shadow_list[i] = shadow_list[i - 1];
    shadow_list[at] = v;
    shadow_count++;
    if (shadow_count == LIST_DEPTH) n_full_hits++;
    return ST_DONE;
  endfunction

  // shadow list: remove the entry at a place below the count
  function automatic void list_take(int at);
    int i;
    for (i = at; i + 1 < int'(shadow_count); i++) shadow_list[i] = shadow_list[i + 1];
    shadow_count--;
    if (shadow_count == 0) n_empty_hits++;
  endfunction

  // apply one word to the shadow list and queue the dump it must produce
  function automatic void predict_dump(op_word_t w, bit typed, status_t t_st, int t_len);
    status_t      st;
    result_word_t r;
    int           k;
    int           n_words;
    st = ST_DONE;
    case (w.operation)
      OP_INS_HEAD: st = list_put(0, w.value);
      OP_INS_TAIL: st = list_put(int'(shadow_count), w.value);
      OP_INS_POS: begin
        if (w.position > shadow_count) st = ST_BADPOS;
        else st = list_put(int'(w.position), w.value);
      end
      OP_DEL_HEAD: begin
        if (shadow_count != 0) list_take(0);
      end
      OP_DEL_TAIL: begin
        if (shadow_count != 0) list_take(int'(shadow_count) - 1);
      end
      OP_DEL_POS: begin
        if (w.position >= shadow_count) st = ST_BADPOS;
        else list_take(int'(w.position));
      end
      default: ;
    endcase
    n_words = (shadow_count == 0) ? 1 : int'(shadow_count);
    // typed script rows carry their own status and dump length
    if (typed) begin
      if (n_words != t_len) begin
        $error("dump length: expected %0d, predicted %0d", t_len, n_words);
        n_fail++;
      end
      st = t_st;
    end
    if (shadow_count == 0) begin
      r            = '0;
      r.status     = st;
      r.list_empty = 1'b1;
      r.last       = 1'b1;
      pending_dump.push_back(r);
    end else begin
      for (k = 0; k < n_words; k++) begin
        r.element       = shadow_list[k];
        r.element_index = k[3:0];
        r.status        = st;
        r.list_empty    = 1'b0;
        r.last          = (k + 1 == n_words);
        pending_dump.push_back(r);
      end
    end
  endfunction

  function automatic logic signed [31:0] draw_value();
    if ($urandom_range(0, 7) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // random word: mostly valid ops biased to sweep the list between empty
  // and full, plus unused codes, no-ops and out-of-range positions
  function automatic op_word_t draw_word();
    op_word_t w;
    int       r;
    int       cnt;
    cnt = int'(shadow_count);
    if (cnt == LIST_DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
    if (cnt == 0) growing = 1'b1;
    w.value    = draw_value();
    w.position = 5'($urandom_range(0, 31));
    r = $urandom_range(0, 99);
    if (r < 5) begin
      w.operation = ($urandom_range(0, 1) != 0) ? OP_UNUSED : OP_NONE;
    end else if (r < 12) begin
      if ($urandom_range(0, 1) != 0) begin
        w.operation = OP_INS_POS;
        w.position  = 5'($urandom_range(cnt + 1, 31));
      end else begin
        w.operation = OP_DEL_POS;
        w.position  = 5'($urandom_range(cnt, 31));
      end
    end else if (growing == ($urandom_range(0, 3) != 0)) begin
      case ($urandom_range(0, 2))
        0:       w.operation = OP_INS_HEAD;
        1:       w.operation = OP_INS_TAIL;
        default: begin
          w.operation = OP_INS_POS;
          w.position  = 5'($urandom_range(0, cnt));
        end
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       w.operation = OP_DEL_HEAD;
        1:       w.operation = OP_DEL_TAIL;
        default: begin
          w.operation = OP_DEL_POS;
          w.position  = 5'((cnt == 0) ? 0 : $urandom_range(0, cnt - 1));
        end
      endcase
    end
    return w;
  endfunction

  // present a word and hold it until the block takes it
  task automatic send_word(op_word_t w, bit typed, status_t t_st, int t_len);
    start <= 1'b1;
    cmd   <= w;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predict_dump(w, typed, t_st, t_len);
    n_sent++;
  endtask

  // random idle burst on the command side
  task automatic sender_gap(bit allowed);
    if (allowed && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // hold off until every queued dump word has come back
  task automatic drain_dumps();
    start <= 1'b0;
    while (pending_dump.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(op_code_t op, logic [31:0] value, logic [4:0] pos, int reps,
                         bit typed, status_t st, int len);
    script_row_t row;
    row = '{op, value, pos, reps, typed, st, len};
    script.push_back(row);
  endtask

  // check each dump word against the oldest expectation
  always @(posedge clk) begin
    result_word_t want;
    if (!rst && result_valid === 1'b1) begin
      if (pending_dump.size() == 0) begin
        $error("unexpected dump word %h", result);
        n_fail++;
      end else begin
        want = pending_dump.pop_front();
        n_checked++;
        if (result.element !== want.element) begin
          $error("element: expected %0d, got %0d", want.element, result.element);
          n_fail++;
        end
        if (result.element_index !== want.element_index) begin
          $error("element_index: expected %0d, got %0d", want.element_index,
                 result.element_index);
          n_fail++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          n_fail++;
        end
        if (result.list_empty !== want.list_empty) begin
          $error("list_empty: expected %0d, got %0d", want.list_empty, result.list_empty);
          n_fail++;
        end
        if (result.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, result.last);
          n_fail++;
        end
      end
    end
  end

  // watchdog: too long with no word taken and no dump word shown
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst || (start && busy === 1'b0) || result_valid === 1'b1) stall = 0;
      else stall++;
      if (stall >= STALL_LIMIT) begin
        $display("timeout: %0d dump words still pending", pending_dump.size());
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    op_word_t    w;
    script_row_t row;
    int          i;
    int          j;
    int          k;
    rst          = 1'b1;
    start        = 1'b0;
    cmd          = '0;
    shadow_count = '0;
    growing      = 1'b1;
    n_fail       = 0;
    n_sent       = 0;
    n_checked    = 0;
    n_full_hits  = 0;
    n_empty_hits = 0;
    for (i = 0; i < LIST_DEPTH; i++) shadow_list[i] = '0;

    // empty list: no-op, deletes on nothing, bad positions
    add_row(OP_NONE,     32'h0000_0000, 5'd0,  1, 1, ST_DONE,   1);
    add_row(OP_DEL_HEAD, 32'h0000_0000, 5'd0,  1, 1, ST_DONE,   1);
    add_row(OP_DEL_TAIL, 32'h0000_0000, 5'd0,  1, 1, ST_DONE,   1);
    add_row(OP_DEL_POS,  32'h0000_0000, 5'd0,  1, 1, ST_BADPOS, 1);
    add_row(OP_INS_POS,  32'h1234_5678, 5'd1,  1, 1, ST_BADPOS, 1);
    // insert at position 0 behaves as a head insert
    add_row(OP_INS_POS,  32'h7fff_ffff, 5'd0,  1, 1, ST_DONE,   1);
    add_row(OP_INS_HEAD, 32'h8000_0000, 5'd0,  1, 0, ST_DONE,   0);
    add_row(OP_INS_TAIL, 32'hffff_ffff, 5'd31, 1, 0, ST_DONE,   0);
    // insert at position == count behaves as a tail insert
    add_row(OP_INS_POS,  32'h0000_0000, 5'd3,  1, 0, ST_DONE,   0);
    add_row(OP_INS_POS,  32'h5555_5555, 5'd1,  1, 0, ST_DONE,   0);
    add_row(OP_UNUSED,   32'haaaa_aaaa, 5'd31, 1, 1, ST_DONE,   5);
    add_row(OP_DEL_POS,  32'h0000_0000, 5'd31, 1, 1, ST_BADPOS, 5);
    add_row(OP_DEL_POS,  32'h0000_0000, 5'd2,  1, 0, ST_DONE,   0);
    // fill up to the full depth
    add_row(OP_INS_TAIL, 32'h0000_0000, 5'd0,  6, 0, ST_DONE,   0);
    add_row(OP_INS_HEAD, 32'h0000_0000, 5'd0,  6, 0, ST_DONE,   0);
    // full list: inserts refused, bad position wins over full
    add_row(OP_INS_HEAD, 32'h0bad_cafe, 5'd0,  1, 1, ST_FULL,   16);
    add_row(OP_INS_TAIL, 32'h0bad_cafe, 5'd0,  1, 1, ST_FULL,   16);
    add_row(OP_INS_POS,  32'h0bad_cafe, 5'd16, 1, 1, ST_FULL,   16);
    add_row(OP_INS_POS,  32'h0bad_cafe, 5'd17, 1, 1, ST_BADPOS, 16);
    add_row(OP_DEL_POS,  32'h0000_0000, 5'd16, 1, 1, ST_BADPOS, 16);
    add_row(OP_DEL_POS,  32'h0000_0000, 5'd15, 1, 0, ST_DONE,   0);
    add_row(OP_DEL_TAIL, 32'h0000_0000, 5'd0,  1, 0, ST_DONE,   0);
    add_row(OP_DEL_HEAD, 32'h0000_0000, 5'd0,  1, 0, ST_DONE,   0);
    add_row(OP_DEL_POS,  32'h0000_0000, 5'd0,  1, 0, ST_DONE,   0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed script
    foreach (script[i]) begin
      row = script[i];
      for (j = 0; j < row.reps; j++) begin
        w.operation = row.op;
        w.value     = (row.reps > 1) ? $urandom : row.value;
        w.position  = row.position;
        send_word(w, row.typed, row.st, row.len);
        sender_gap(1'b1);
      end
    end
    drain_dumps();

    // random part; a burst-free stretch in the middle and at the end
    for (k = 0; k < N_RANDOM; k++) begin
      w = draw_word();
      send_word(w, 1'b0, ST_DONE, 0);
      if (k == 100 || k == 230) drain_dumps();
      else sender_gap(k < N_RANDOM - 60 && !(k >= 140 && k < 190));
    end

    start <= 1'b0;
    while (pending_dump.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d command words sent, %0d dump words checked", n_sent, n_checked);
    $display("list filled %0d times, emptied %0d times", n_full_hits, n_empty_hits);
    if (n_fail == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
